// ===== sv/tcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Field widths of the channels.
    localparam int ACTION_W     = 1;
    localparam int CHAR_W       = 8;
    localparam int READ_ROW_W   = 5;
    localparam int READ_COL_W   = 7;
    localparam int CURSOR_POS_W = 11;
    localparam int ATTR_W       = 8;
    localparam int CELL_W       = CHAR_W + ATTR_W;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_PUT  = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_READ = 1'b1;

    // Character and attribute constants.
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0A;

    // One command item as latched by the sequencer.
    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [CHAR_W-1:0]     char_code;
        logic [READ_ROW_W-1:0] read_row;
        logic [READ_COL_W-1:0] read_column;
    } cmd_item_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUT,
        ST_RD_ISSUE,
        ST_RD_DATA,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_SCR_ZERO,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

// ===== sv/tcw_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Command channel: put a character or read one cell.
interface tcw_in_if
    import tcw_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [CHAR_W-1:0]     char_code;
    logic [READ_ROW_W-1:0] read_row;
    logic [READ_COL_W-1:0] read_column;

    modport source (output valid, action, char_code, read_row, read_column, input ready);
    modport sink   (input valid, action, char_code, read_row, read_column, output ready);
endinterface

// Result channel: cursor position and the cell that was read.
interface tcw_out_if
    import tcw_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CURSOR_POS_W-1:0] cursor_pos;
    logic [CHAR_W-1:0]       cell_char;
    logic [ATTR_W-1:0]       cell_attr;

    modport source (output valid, cursor_pos, cell_char, cell_attr, input ready);
    modport sink   (input valid, cursor_pos, cell_char, cell_attr, output ready);
endinterface

// Configuration channel: the text attribute register.
interface tcw_cfg_if
    import tcw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ATTR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== sv/tcw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire                      re,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/text_console_writer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Text console writer.
// The cmd channel takes one item at a time: action 0 puts char_code at the
// cursor (10 is a newline), action 1 reads the cell at read_row/read_column.
// Each item gives one item on the result channel with the linear cursor
// position and, for reads, the cell's character and attribute. The cfg channel
// sets the attribute stored with every written character; it is always ready.
// After reset the cell memory is cleared one cell per cycle, and cmd.ready
// stays low until that is done. A put at the end of a row wraps to the next
// row before it writes. The sequencer is back in idle as the result appears,
// so the next item can be accepted in the cycle in which the result appears.
// A put that finds the cursor past the bottom scrolls first: the sequencer
// sees the cursor past the bottom, then the memory read and write ports move
// each cell one row up, a read and then a write per cell, and zero the last
// row one cell per cycle. A put scrolls at most once. A result waits in an
// output register while result.ready is low; the sequencer holds in its
// response state until that register is free.
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire         clk,
    input  wire         rst_n,
    tcw_in_if.sink      cmd,
    tcw_out_if.source   result,
    tcw_cfg_if.sink     cfg
);

    localparam int TOTAL  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int POS_W  = $clog2(TOTAL + 1);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ROW_W  = $clog2(ROWS + 1);

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(TOTAL - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  COL_END   = COL_W'(COLUMNS);
    localparam logic [ROW_W-1:0]  ROW_END   = ROW_W'(ROWS);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);

    state_t state_reg, state_next;

    cmd_item_t         item_reg, item_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ATTR_W-1:0] attr_reg;
    logic [CELL_W-1:0] cell_reg, cell_next;

    logic                    out_valid_reg, out_valid_next;
    logic [CURSOR_POS_W-1:0] out_pos_reg, out_pos_next;
    logic [CELL_W-1:0]       out_cell_reg, out_cell_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic              cmd_fire;
    logic              out_free;
    logic              past_bottom;
    logic              col_full;
    logic              is_newline;
    logic              read_in_range;
    logic [POS_W-1:0]  cursor_lin;
    logic [ADDR_W-1:0] read_addr;

    // Cell memory.
    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (TOTAL)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshakes and decoded conditions.
    assign cmd.ready    = (state_reg == ST_IDLE);
    assign cmd_fire     = cmd.valid && cmd.ready;
    assign cfg.ready    = 1'b1;
    assign out_free     = !out_valid_reg || result.ready;
    assign past_bottom  = (row_reg == ROW_END);
    assign col_full     = (col_reg == COL_END);
    assign is_newline   = (item_reg.char_code == NEWLINE_CODE);
    assign cursor_lin   = POS_W'(row_reg) * POS_W'(COLUMNS) + POS_W'(col_reg);
    assign read_in_range = (32'(item_reg.read_row) < ROWS) &&
                           (32'(item_reg.read_column) < COLUMNS);
    assign read_addr    = ADDR_W'(POS_W'(item_reg.read_row) * POS_W'(COLUMNS)
                                  + POS_W'(item_reg.read_column));

    assign result.valid      = out_valid_reg;
    assign result.cursor_pos = out_pos_reg;
    assign result.cell_char  = out_cell_reg[CHAR_W-1:0];
    assign result.cell_attr  = out_cell_reg[CELL_W-1:CHAR_W];

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (idx_reg == ADDR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = (cmd.action == ACT_READ) ? ST_RD_ISSUE : ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (past_bottom)
                begin
                    state_next = ST_SCR_RD;
                end
                else if (is_newline || !col_full)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RD_ISSUE:
            begin
                state_next = read_in_range ? ST_RD_DATA : ST_RESP;
            end
            ST_RD_DATA:
            begin
                state_next = ST_RESP;
            end
            ST_SCR_RD:
            begin
                state_next = ST_SCR_WR;
            end
            ST_SCR_WR:
            begin
                state_next = (idx_reg == COPY_LAST) ? ST_SCR_ZERO : ST_SCR_RD;
            end
            ST_SCR_ZERO:
            begin
                if (idx_reg == ADDR_LAST)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control for each state.
    always_comb
    begin
        item_next      = item_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        idx_next       = idx_reg;
        cell_next      = cell_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_pos_next   = out_pos_reg;
        out_cell_next  = out_cell_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg + ROW_STEP;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                idx_next = (idx_reg == ADDR_LAST) ? '0 : idx_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    item_next.action      = cmd.action;
                    item_next.char_code   = cmd.char_code;
                    item_next.read_row    = cmd.read_row;
                    item_next.read_column = cmd.read_column;
                    cell_next             = '0;
                end
            end
            ST_PUT:
            begin
                if (past_bottom)
                begin
                    // Scroll before anything else; the copy starts at cell 0.
                    idx_next = '0;
                end
                else if (is_newline || col_full)
                begin
                    // Newline, or a wrap that retries the write on the next row.
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(cursor_lin);
                    ram_wdata = {attr_reg, item_reg.char_code};
                    col_next  = col_reg + 1'b1;
                end
            end
            ST_RD_ISSUE:
            begin
                ram_re    = read_in_range;
                ram_raddr = read_addr;
            end
            ST_RD_DATA:
            begin
                cell_next = ram_rdata;
            end
            ST_SCR_RD:
            begin
                // Fetch the cell one row below the destination.
                ram_re = 1'b1;
            end
            ST_SCR_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                idx_next  = idx_reg + 1'b1;
            end
            ST_SCR_ZERO:
            begin
                ram_we = 1'b1;
                if (idx_reg == ADDR_LAST)
                begin
                    idx_next = '0;
                    row_next = ROW_LAST;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = CURSOR_POS_W'(cursor_lin);
                    out_cell_next  = cell_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            col_reg       <= '0;
            row_reg       <= '0;
            idx_reg       <= '0;
            attr_reg      <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                attr_reg <= cfg.data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        cell_reg     <= cell_next;
        out_pos_reg  <= out_pos_next;
        out_cell_reg <= out_cell_next;
    end

    // The cursor sits past the bottom only at column 0.
    a_bottom_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
        past_bottom |-> (col_reg == '0))
        else $error("cursor past the bottom with a nonzero column");

    // The column never runs beyond one past the last cell of a row, nor the row beyond one past the last row.
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) <= COLUMNS) && (32'(row_reg) <= ROWS))
        else $error("cursor out of bounds");

    // An accepted item blocks the command channel in the next cycle.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> !cmd.ready)
        else $error("command accepted twice in a row");

    // The end of a scroll leaves the cursor on the last row.
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCR_ZERO && idx_reg == ADDR_LAST) |=> (row_reg == ROW_LAST))
        else $error("scroll did not move the cursor to the last row");

    // The memory is never written while the sequencer waits for an item or for the result register to be free.
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_RESP) |-> !ram_we)
        else $error("memory write outside an active step");

endmodule

`default_nettype wire
